@@ rtl/fpra_pkg.sv @@
// ----------------------------------------------------------------------------
// fpra_pkg: shared types and constants for the fixed-point rounding ALU
// ----------------------------------------------------------------------------
`default_nettype none
package fpra_pkg;
  localparam int MaxWidth = 32;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    RND_ZERO = 2'd0,
    RND_EVEN = 2'd1,
    RND_POS  = 2'd2,
    RND_NEG  = 2'd3
  } round_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DIVZ   = 2'd1,
    ST_BADFMT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_INT_BITS   = 2'd0,
    CFG_FRAC_BITS  = 2'd1,
    CFG_ROUND_MODE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] left_operand;
    logic [31:0] right_operand;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } out_item_t;

  // One item moving down the pipe. Operands are sign-extended magnitudes.
  typedef struct packed {
    logic        short_path;  // add/sub/error: result already final
    logic [63:0] quot;        // quotient bits (divider shifts into this)
    logic [63:0] rem;         // partial remainder
    logic [63:0] den;         // divisor magnitude
    logic        neg;         // result sign
    logic [63:0] direct;      // final value for the short path
    logic [1:0]  status;
  } lane_t;
endpackage
`default_nettype wire

@@ rtl/fpra_if.sv @@
// ----------------------------------------------------------------------------
// fpra_if: valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
`default_nettype none
interface fpra_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/fpra_div_stage.sv @@
// ----------------------------------------------------------------------------
// fpra_div_stage: eight restoring-division steps on one pipelined item
// ----------------------------------------------------------------------------
`default_nettype none
module fpra_div_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire fpra_pkg::lane_t lane_i,
  output logic                valid_o,
  output fpra_pkg::lane_t     lane_o
);
  import fpra_pkg::*;

  lane_t lane_d, lane_q;
  logic  valid_q;

  always_comb begin
    logic [64:0] trial;
    lane_d = lane_i;
    for (int k = 0; k < 8; k++) begin
      trial = {lane_d.rem, lane_d.quot[63]} - {1'b0, lane_d.den};
      lane_d.quot = {lane_d.quot[62:0], ~trial[64]};
      if (!trial[64]) begin
        lane_d.rem = trial[63:0];
      end else begin
        lane_d.rem = {lane_d.rem[62:0], lane_i.quot[63 - k]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;
endmodule
`default_nettype wire

@@ rtl/fixed_point_rounding_alu.sv @@
// Pipeline: 10 register stages from an accepted input transaction to the result
// (1 prepare, 8 divide stages of 8 quotient bits each, 1 round/output register).
// Throughput: one transaction per cycle; all operations flow through the same
// pipe, and a stall on the output freezes every stage together.
// Reset: clears stage valid bits; format resets to Q16.16, round toward zero.
// ----------------------------------------------------------------------------
// fixed_point_rounding_alu: signed Qa.b add/sub/mul/div with rounding modes
// ----------------------------------------------------------------------------
`default_nettype none
module fixed_point_rounding_alu (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [5:0] cfg_data_i,
  fpra_if.sink       in_if,
  fpra_if.source     out_if
);
  import fpra_pkg::*;

  localparam int NDiv = 8;

  // Configuration registers
  logic [5:0] int_bits_q;
  logic [4:0] frac_bits_q;
  logic [1:0] round_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_bits_q   <= 6'd16;
      frac_bits_q  <= 5'd16;
      round_mode_q <= RND_ZERO;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_INT_BITS:   int_bits_q   <= cfg_data_i;
        CFG_FRAC_BITS:  frac_bits_q  <= cfg_data_i[4:0];
        CFG_ROUND_MODE: round_mode_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Whole pipe advances when the output register is free or being drained.
  logic en;
  logic out_valid_q;
  assign en          = !out_valid_q || out_if.ready;
  assign in_if.ready = en;

  // --------------------------------------------------------------------------
  // Stage 1: decode format, sign-extend, multiply, set up the dividend.
  // Multiply becomes a division by 2^b so that one rounding path serves both.
  // --------------------------------------------------------------------------
  logic [6:0]  w;
  logic        bad_fmt;
  logic [31:0] wmask;
  logic signed [63:0] x, y;
  logic [63:0] ax, ay;
  logic        sx, sy;

  assign w       = {1'b0, int_bits_q} + {2'b0, frac_bits_q};
  assign bad_fmt = (int_bits_q == 6'd0) || (w > 7'(MaxWidth));
  assign wmask   = (w >= 7'd32) ? 32'hFFFF_FFFF : ((32'd1 << w[4:0]) - 32'd1);

  always_comb begin
    logic [31:0] lm, rm, sb;
    sb = 32'd1 << (w[4:0] - 5'd1);
    lm = in_if.data.left_operand & wmask;
    rm = in_if.data.right_operand & wmask;
    x  = ((lm & sb) != 32'd0) ? 64'(signed'(lm | ~wmask)) : 64'(lm);
    y  = ((rm & sb) != 32'd0) ? 64'(signed'(rm | ~wmask)) : 64'(rm);
    sx = x[63];
    sy = y[63];
    ax = sx ? -x : x;
    ay = sy ? -y : y;
  end

  lane_t lane0;
  logic  [63:0] prod_mag;
  assign prod_mag = ax[31:0] * ay[31:0];

  always_comb begin
    lane0        = '0;
    lane0.status = ST_OK;
    if (bad_fmt) begin
      lane0.short_path = 1'b1;
      lane0.status     = ST_BADFMT;
    end else begin
      case (kind_e'(in_if.data.kind))
        KIND_ADD: begin
          lane0.short_path = 1'b1;
          lane0.direct     = x + y;
        end
        KIND_SUB: begin
          lane0.short_path = 1'b1;
          lane0.direct     = x - y;
        end
        KIND_MUL: begin
          lane0.quot = prod_mag;
          lane0.den  = 64'd1 << frac_bits_q;
          lane0.neg  = (sx ^ sy) && (prod_mag != 64'd0);
        end
        default: begin
          if (ay == 64'd0) begin
            lane0.short_path = 1'b1;
            lane0.status     = ST_DIVZ;
          end else begin
            lane0.quot = ax << frac_bits_q;
            lane0.den  = ay;
            lane0.neg  = (sx ^ sy) && (ax != 64'd0);
          end
        end
      endcase
    end
  end

  logic  s1_valid_q;
  lane_t s1_lane_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_if.valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_lane_q <= lane0;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 2..9: restoring division, 8 quotient bits per stage.
  // Rounding mode and width travel alongside through a shift line.
  // --------------------------------------------------------------------------
  logic  dv_valid [NDiv+1];
  lane_t dv_lane  [NDiv+1];
  logic [1:0] rm_line_q [NDiv+1];
  logic [6:0] w_line_q  [NDiv+1];

  assign dv_valid[0] = s1_valid_q;
  assign dv_lane[0]  = s1_lane_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rm_line_q[0] <= round_mode_q;
      w_line_q[0]  <= w;
      for (int i = 0; i < NDiv; i++) begin
        rm_line_q[i+1] <= rm_line_q[i];
        w_line_q[i+1]  <= w_line_q[i];
      end
    end
  end

  for (genvar g = 0; g < NDiv; g++) begin : g_div
    fpra_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_valid[g]),
      .lane_i  (dv_lane[g]),
      .valid_o (dv_valid[g+1]),
      .lane_o  (dv_lane[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Final stage: round, apply sign, wrap to W bits into the output register.
  // --------------------------------------------------------------------------
  lane_t      fl;
  logic [1:0] frm;
  logic [6:0] fw;
  logic [31:0] res_d;

  assign fl  = dv_lane[NDiv];
  assign frm = rm_line_q[NDiv];
  assign fw  = w_line_q[NDiv];

  always_comb begin
    logic        up, rnz;
    logic [63:0] q, half, r64;
    logic [31:0] m, sb, v;
    q    = fl.quot;
    r64  = fl.rem;
    rnz  = (r64 != 64'd0);
    half = fl.den - r64;
    up   = 1'b0;
    case (round_e'(frm))
      RND_EVEN: up = (r64 > half) || ((r64 == half) && rnz && q[0]);
      RND_POS:  up = !fl.neg && rnz;
      RND_NEG:  up = fl.neg && rnz;
      default:  up = 1'b0;
    endcase
    q = q + 64'(up);
    if (fl.neg) begin
      q = -q;
    end
    if (fl.short_path) begin
      q = fl.direct;
    end
    m  = (fw >= 7'd32) ? 32'hFFFF_FFFF : ((32'd1 << fw[4:0]) - 32'd1);
    sb = 32'd1 << (fw[4:0] - 5'd1);
    v  = q[31:0] & m;
    if ((v & sb) != 32'd0) begin
      v = v | ~m;
    end
    res_d = (fl.status == ST_OK) ? v : 32'd0;
  end

  out_item_t out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid[NDiv];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.result_value <= res_d;
      out_q.status       <= fl.status;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;
endmodule
`default_nettype wire

@@ rtl/fpra_checker.sv @@
// ----------------------------------------------------------------------------
// fpra_checker: port-level checks on the fixed-point rounding ALU
// ----------------------------------------------------------------------------
`default_nettype none
module fpra_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic [1:0] out_status_i
);
  import fpra_pkg::*;

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((out_status_i == ST_OK) || (out_status_i == ST_DIVZ) ||
                     (out_status_i == ST_BADFMT))) else $error("illegal status");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i) else $error("input blocked with empty output");
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i) else $error("input blocked while draining");
endmodule

bind fixed_point_rounding_alu fpra_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .out_status_i(out_if.data.status)
);
`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the fixed-point rounding ALU
// ----------------------------------------------------------------------------
// Sends directed and random operations through the input channel, predicts
// each result from the current format and rounding mode, and compares every
// output transaction in order against the queue of predicted results. The
// format and rounding mode change between phases, only while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  import fpra_pkg::*;

  localparam int Latency = 11;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [5:0] cfg_data_i;

  fpra_if #(.T(in_item_t))  in_ch ();
  fpra_if #(.T(out_item_t)) out_ch ();

  fixed_point_rounding_alu u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  // Shadow copy of the format and rounding registers.
  int unsigned int_bits_q;
  int unsigned frac_bits_q;
  round_e      round_q;

  in_item_t  op_pending[$];
  out_item_t result_expected[$];
  int        err_cnt;
  bit        quiet_mode;   // no idling on either side in the last part
  bit        gen_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Signed division with the configured rounding; d is nonzero.
  function automatic logic [63:0] round_div(logic [63:0] n, logic [63:0] d);
    logic [63:0] an, ad, q, r;
    logic        neg, up;
    an  = n[63] ? -n : n;
    ad  = d[63] ? -d : d;
    q   = an / ad;
    r   = an % ad;
    neg = (n[63] != d[63]) && an != 0;
    up  = 1'b0;
    case (round_q)
      RND_EVEN: up = (r > ad - r) || (r == ad - r && r != 0 && q[0]);
      RND_POS:  up = !neg && r != 0;
      RND_NEG:  up = neg && r != 0;
      default:  up = 1'b0;
    endcase
    if (up) q = q + 1;
    return neg ? -q : q;
  endfunction

  function automatic logic [63:0] widen(logic [31:0] v, int unsigned w);
    logic [63:0] m;
    m = (64'd1 << w) - 1;
    widen = {32'd0, v} & m;
    if (widen[w-1]) widen = widen | ~m;
  endfunction

  function automatic out_item_t compute_alu(in_item_t it);
    out_item_t   o;
    int unsigned w;
    logic [63:0] x, y, r, wr;
    w = int_bits_q + frac_bits_q;
    o.status = ST_OK;
    if (int_bits_q == 0 || w > MaxWidth) begin
      o.result_value = '0;
      o.status = ST_BADFMT;
      return o;
    end
    x = widen(it.left_operand, w);
    y = widen(it.right_operand, w);
    case (kind_e'(it.kind))
      KIND_ADD: r = x + y;
      KIND_SUB: r = x - y;
      KIND_MUL: r = round_div(x * y, 64'd1 << frac_bits_q);
      default: begin
        if (y == 0) begin
          o.result_value = '0;
          o.status = ST_DIVZ;
          return o;
        end
        if (x[63]) r = -((-x) << frac_bits_q);
        else r = x << frac_bits_q;
        r = round_div(r, y);
      end
    endcase
    wr = widen(r[31:0], w);
    o.result_value = wr[31:0];
    return o;
  endfunction

  // Driver: hold valid until accepted, idle in random bursts.
  int drv_idle;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
      drv_idle    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        result_expected.push_back(compute_alu(in_ch.data));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (drv_idle > 0) begin
          drv_idle    <= drv_idle - 1;
          in_ch.valid <= 1'b0;
        end else if (op_pending.size() > 0) begin
          in_ch.data  <= op_pending.pop_front();
          in_ch.valid <= 1'b1;
          if (!quiet_mode && $urandom_range(0, 9) == 0) drv_idle <= $urandom_range(1, 16);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output transaction against the oldest prediction.
  int mon_idle;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      mon_idle     <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (result_expected.size() == 0) begin
          $error("unexpected result %h status %0d", out_ch.data.result_value,
                 out_ch.data.status);
          err_cnt++;
        end else begin
          out_item_t e;
          e = result_expected.pop_front();
          if (out_ch.data.result_value !== e.result_value) begin
            $error("result_value: expected %h actual %h", e.result_value,
                   out_ch.data.result_value);
            err_cnt++;
          end
          if (out_ch.data.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, out_ch.data.status);
            err_cnt++;
          end
        end
      end
      if (mon_idle > 0) begin
        mon_idle     <= mon_idle - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
        mon_idle     <= $urandom_range(1, 16);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Wait until the unit is idle: nothing queued, nothing in flight.
  task automatic drain();
    while (op_pending.size() > 0 || in_ch.valid || result_expected.size() > 0)
      @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [5:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_INT_BITS:  int_bits_q = val;
      CFG_FRAC_BITS: frac_bits_q = val[4:0];
      default:       round_q = round_e'(val[1:0]);
    endcase
  endtask

  task automatic set_format(int unsigned ib, int unsigned fb, round_e rm);
    drain();
    write_reg(CFG_INT_BITS, ib[5:0]);
    write_reg(CFG_FRAC_BITS, fb[5:0]);
    write_reg(CFG_ROUND_MODE, {4'd0, rm});
  endtask

  task automatic push_op(kind_e k, logic [31:0] l, logic [31:0] r);
    in_item_t it;
    it.kind = k;
    it.left_operand = l;
    it.right_operand = r;
    op_pending.push_back(it);
  endtask

  // Random operand biased toward small magnitudes and the edges of the format.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 7);
      1:       return -$urandom_range(1, 7);
      2:       return 32'h8000_0000 >> $urandom_range(0, 31);
      3:       return ~(32'h8000_0000 >> $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  task automatic random_ops(int n);
    for (int i = 0; i < n; i++) begin
      push_op(kind_e'($urandom_range(0, 3)), pick_operand(), pick_operand());
    end
  endtask

  initial begin
    int unsigned ib, fb;
    err_cnt    = 0;
    quiet_mode = 0;
    gen_done   = 0;
    int_bits_q = 16;
    frac_bits_q = 16;
    round_q    = RND_ZERO;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_INT_BITS;
    cfg_data_i = '0;
    rst_ni     = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset format Q16.16, every kind, extremes, zero operands.
    push_op(KIND_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
    push_op(KIND_SUB, 32'h8000_0000, 32'h0000_0001);
    push_op(KIND_MUL, 32'h0001_8000, 32'h0000_8000);
    push_op(KIND_MUL, 32'hFFFE_8000, 32'h0000_8000);
    push_op(KIND_MUL, 32'h0000_0000, 32'hFFFF_FFFF);
    push_op(KIND_DIV, 32'h0001_0000, 32'h0003_0000);
    push_op(KIND_DIV, 32'hFFFF_0000, 32'h0003_0000);
    push_op(KIND_DIV, 32'h1234_5678, 32'hFFFF_0000);   // negative divisor
    push_op(KIND_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    push_op(KIND_DIV, 32'h0000_0000, 32'h0000_0001);
    push_op(KIND_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_op(KIND_MUL, 32'h8000_0000, 32'h8000_0000);
    // Hold the sender until every predicted result has come back.
    drain();
    for (int m = 0; m < 4; m++) begin
      set_format(16, 16, round_e'(m));
      push_op(KIND_MUL, 32'h0000_8000, 32'h0000_0001);   // tie at one half
      push_op(KIND_MUL, 32'h0001_8000, 32'h0000_8000);
      push_op(KIND_MUL, 32'hFFFF_4000, 32'h0000_8000);
      push_op(KIND_DIV, 32'hFFFF_0000, 32'h0003_0000);
    end
    // Invalid formats: no integer bits, and a width past the maximum.
    set_format(0, 8, RND_ZERO);
    push_op(KIND_ADD, 32'd1, 32'd2);
    set_format(32, 31, RND_EVEN);
    push_op(KIND_DIV, 32'd1, 32'd0);
    // Narrowest and widest valid formats.
    set_format(1, 0, RND_POS);
    push_op(KIND_ADD, 32'd1, 32'd1);
    push_op(KIND_DIV, 32'd1, 32'd0);
    set_format(1, 31, RND_NEG);
    push_op(KIND_MUL, 32'h8000_0000, 32'h8000_0000);
    push_op(KIND_DIV, 32'h8000_0001, 32'h7FFF_FFFF);
    set_format(32, 0, RND_EVEN);
    push_op(KIND_DIV, 32'h8000_0000, 32'd2);

    // Random phases across formats; about one in five may be invalid.
    for (int ph = 0; ph < 16; ph++) begin
      if (ph == 14) begin
        drain();
        quiet_mode = 1;
      end
      ib = $urandom_range(1, 32);
      fb = $urandom_range(0, 32 - ib);
      if ($urandom_range(0, 4) == 0) begin
        ib = $urandom_range(0, 63);
        fb = $urandom_range(0, 31);
      end
      set_format(ib, fb, round_e'($urandom_range(0, 3)));
      random_ops(50);
    end
    drain();
    gen_done = 1;
  end

  initial begin
    wait (gen_done);
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
rtl/fpra_pkg.sv
rtl/fpra_if.sv
rtl/fpra_div_stage.sv
rtl/fixed_point_rounding_alu.sv
rtl/fpra_checker.sv
verif/tb.sv
